// File: src/cps_pkg.sv
// shared constants and types for the codestream packet splitter
package cps_pkg;

    localparam int CPS_COUNT_BITS = 32;
    localparam int CPS_BYTE_W     = 8;
    localparam int CPS_WORD_W     = 32;
    localparam int CPS_CFG_IDX_W  = 1;

    localparam logic [CPS_BYTE_W-1:0] MARK_FF  = 8'hFF;
    localparam logic [CPS_BYTE_W-1:0] MARK_SOP = 8'h91;
    localparam logic [CPS_BYTE_W-1:0] MARK_EOC = 8'hD9;

    typedef enum logic [CPS_CFG_IDX_W-1:0] {
        REG_BASE_OFFSET     = 1'b0,
        REG_MIN_BLOCK_BYTES = 1'b1
    } cps_reg_idx_t;

endpackage

// File: src/cps_ifs.sv
// valid/ready channel interfaces for bytes, packet records and register writes
interface cps_byte_if import cps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CPS_BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface cps_packet_if import cps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CPS_WORD_W-1:0] packet_offset;
    logic [CPS_WORD_W-1:0] packet_length;
    logic [CPS_WORD_W-1:0] block_number;
    logic                  closes_block;
    logic                  end_of_stream;

    modport source (output valid, output packet_offset, output packet_length,
                    output block_number, output closes_block, output end_of_stream,
                    input ready);
    modport sink   (input valid, input packet_offset, input packet_length,
                    input block_number, input closes_block, input end_of_stream,
                    output ready);
endinterface

interface cps_cfg_if import cps_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CPS_CFG_IDX_W-1:0] index;
    logic [CPS_WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/codestream_packet_splitter.sv
// top level: splits a tile body byte stream into packet records at FF 91 / FF D9
//
// Takes one codestream byte per beat and can take a byte every clock as long as
// results are drained. A byte passes an input register and is then resolved
// against the marker state; the 91 or D9 that ends a packet loads its record
// into the output register, from which it is shown. While a record waits, a byte
// that ends another packet is held in the input register, and bytes that end
// no packet keep flowing. After FF D9 all bytes are taken and dropped until reset.
// Register writes (index 0 base_offset, index 1 min_block_bytes) are taken at
// any time and must only be issued while the block is idle; writing base_offset
// restarts the current packet at the new position.
module codestream_packet_splitter import cps_pkg::*;
#(
    parameter int COUNT_BITS = CPS_COUNT_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    cps_byte_if.sink            byte_stream,
    cps_packet_if.source        packet_stream,
    cps_cfg_if.sink             cfg
);

    localparam int CW = COUNT_BITS;

    // configuration
    logic [CPS_WORD_W-1:0] base_offset_reg;
    logic [CPS_WORD_W-1:0] base_offset_next;
    logic [CPS_WORD_W-1:0] min_block_reg;
    logic [CPS_WORD_W-1:0] min_block_next;
    logic                  cfg_fire;
    logic                  restart;

    // input register
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [CPS_BYTE_W-1:0] in_byte_reg;
    logic                  in_fire;

    // packet state
    logic                  pending_ff_reg;
    logic                  pending_ff_next;
    logic [CW-1:0]         length_reg;
    logic [CW-1:0]         length_next;
    logic [CW-1:0]         start_reg;
    logic [CW-1:0]         start_next;
    logic [CW-1:0]         position_reg;
    logic [CW-1:0]         position_next;
    logic                  finished_reg;
    logic                  finished_next;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CPS_WORD_W-1:0] out_offset_reg;
    logic [CPS_WORD_W-1:0] out_length_reg;
    logic [CPS_WORD_W-1:0] out_block_reg;
    logic                  out_closes_reg;
    logic                  out_eos_reg;

    logic                  is_ff;
    logic                  is_end;
    logic                  is_eoc;
    logic                  pkt_end;
    logic                  advance;
    logic                  out_load;
    logic                  closes;
    logic [CW-1:0]         block_number;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_comb
    begin
        base_offset_next = base_offset_reg;
        min_block_next   = min_block_reg;
        restart          = 1'b0;
        if (cfg_fire)
        begin
            unique case (cps_reg_idx_t'(cfg.index))
                REG_BASE_OFFSET:
                begin
                    base_offset_next = cfg.data;
                    restart          = 1'b1;
                end
                REG_MIN_BLOCK_BYTES:
                begin
                    min_block_next = cfg.data;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // byte decode
    assign is_ff   = (in_byte_reg == MARK_FF);
    assign is_eoc  = (in_byte_reg == MARK_EOC);
    assign is_end  = pending_ff_reg && ((in_byte_reg == MARK_SOP) || is_eoc);
    assign pkt_end = advance && !finished_reg && is_end;

    // a byte that ends no packet never waits on the output side
    assign advance  = in_valid_reg &&
                      (finished_reg || !is_end || !out_valid_reg || packet_stream.ready);
    assign out_load = pkt_end;

    assign byte_stream.ready = !in_valid_reg || advance;
    assign in_fire           = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pending_ff_next = pending_ff_reg;
        length_next     = length_reg;
        start_next      = start_reg;
        position_next   = position_reg;
        finished_next   = finished_reg;
        if (advance && !finished_reg)
        begin
            position_next = position_reg + CW'(1);
            if (!pending_ff_reg)
            begin
                pending_ff_next = is_ff;
                if (!is_ff)
                begin
                    length_next = length_reg + CW'(1);
                end
            end
            else if (!is_end)
            begin
                // lone FF counts as data, this byte is taken again
                pending_ff_next = is_ff;
                length_next     = length_reg + (is_ff ? CW'(1) : CW'(2));
            end
            else
            begin
                pending_ff_next = 1'b0;
                start_next      = position_reg - CW'(1);
                length_next     = CW'(2);
                finished_next   = is_eoc;
            end
        end
        if (restart)
        begin
            pending_ff_next = 1'b0;
            length_next     = CW'(2);
            start_next      = CW'(base_offset_next);
            position_next   = CW'((CPS_WORD_W + 1)'(base_offset_next) + (CPS_WORD_W + 1)'(2));
        end
    end

    cps_block_acc #(
        .COUNT_BITS (COUNT_BITS)
    ) u_block_acc (
        .clk             (clk),
        .rst_n           (rst_n),
        .min_block_bytes (min_block_reg),
        .pkt_end         (pkt_end),
        .pkt_length      (length_reg),
        .block_number    (block_number),
        .closes          (closes)
    );

    assign out_valid_next = out_load || (out_valid_reg && !packet_stream.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_offset_reg <= '0;
            min_block_reg   <= CPS_WORD_W'(1);
            in_valid_reg    <= 1'b0;
            pending_ff_reg  <= 1'b0;
            length_reg      <= CW'(2);
            start_reg       <= '0;
            position_reg    <= CW'(2);
            finished_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            base_offset_reg <= base_offset_next;
            min_block_reg   <= min_block_next;
            in_valid_reg    <= in_valid_next;
            pending_ff_reg  <= pending_ff_next;
            length_reg      <= length_next;
            start_reg       <= start_next;
            position_reg    <= position_next;
            finished_reg    <= finished_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= byte_stream.data_byte;
        end
        if (out_load)
        begin
            out_offset_reg <= CPS_WORD_W'(start_reg);
            out_length_reg <= CPS_WORD_W'(length_reg);
            out_block_reg  <= CPS_WORD_W'(block_number);
            out_closes_reg <= closes;
            out_eos_reg    <= is_eoc;
        end
    end

    assign packet_stream.valid         = out_valid_reg;
    assign packet_stream.packet_offset = out_offset_reg;
    assign packet_stream.packet_length = out_length_reg;
    assign packet_stream.block_number  = out_block_reg;
    assign packet_stream.closes_block  = out_closes_reg;
    assign packet_stream.end_of_stream = out_eos_reg;

endmodule

// File: src/cps_block_acc.sv
// block fill accumulator and block counter for finished packets
module cps_block_acc import cps_pkg::*;
#(
    parameter int COUNT_BITS = CPS_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CPS_WORD_W-1:0] min_block_bytes,
    input  logic                  pkt_end,
    input  logic [COUNT_BITS-1:0] pkt_length,
    output logic [COUNT_BITS-1:0] block_number,
    output logic                  closes
);

    localparam int SUM_W = ((COUNT_BITS > CPS_WORD_W) ? COUNT_BITS : CPS_WORD_W) + 1;

    logic [CPS_WORD_W-1:0] fill_reg;
    logic [CPS_WORD_W-1:0] fill_next;
    logic [COUNT_BITS-1:0] counter_reg;
    logic [COUNT_BITS-1:0] counter_next;
    logic [SUM_W-1:0]      sum;

    // fill stays below the minimum between packets, so the sum cannot overflow
    assign sum    = SUM_W'(fill_reg) + SUM_W'(pkt_length);
    assign closes = (sum >= SUM_W'(min_block_bytes));
    assign block_number = counter_reg;

    always_comb
    begin
        fill_next    = fill_reg;
        counter_next = counter_reg;
        if (pkt_end)
        begin
            if (closes)
            begin
                fill_next    = '0;
                counter_next = counter_reg + COUNT_BITS'(1);
            end
            else
            begin
                fill_next = sum[CPS_WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            counter_reg <= '0;
        end
        else
        begin
            fill_reg    <= fill_next;
            counter_reg <= counter_next;
        end
    end

endmodule
